>>> hdl/dorq_pkg.sv
// dorq_pkg: shared widths, codes and command type for the date-ordered request queue
// used by every module under hdl/; depends on nothing
`default_nettype none

package dorq_pkg;

  // default sizes of the slot array
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 16;

  // port field widths
  localparam int MODE_W  = 2;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int TAG_W   = 16;
  localparam int FILL_W  = 5;
  localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;

  // depth of the command queue between front and back
  localparam int CMDQ_DEPTH = 2;

  // request mode codes on the input port
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  // internal operation after classification
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_QUERY
  } dorq_op_t;

  // date key: year, then month, then day, so a plain compare orders dates
  typedef logic [KEY_W-1:0] dorq_key_t;

  typedef struct packed {
    dorq_op_t  op;
    dorq_key_t key;
  } dorq_cmd_t;

endpackage

`default_nettype wire

>>> hdl/dorq_front.sv
// dorq_front: accepts request transfers, classifies the mode and forms the date key
// depends on dorq_pkg
`default_nettype none

module dorq_front #(
  parameter int TAG_BITS = dorq_pkg::TAG_BITS_DEF
) (
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [dorq_pkg::MODE_W-1:0]        in_mode,
  input  wire  [dorq_pkg::YEAR_W-1:0]        in_entry_year,
  input  wire  [dorq_pkg::MONTH_W-1:0]       in_entry_month,
  input  wire  [dorq_pkg::DAY_W-1:0]         in_entry_day,
  input  wire  [dorq_pkg::TAG_W-1:0]         in_entry_tag,
  output logic                               push_valid,
  input  wire                                push_ready,
  output dorq_pkg::dorq_cmd_t                push_cmd,
  output logic [TAG_BITS-1:0]                push_tag
);
  import dorq_pkg::*;

  logic [31:0] tag_wide;

  // handshake goes straight to the command queue
  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  // mode decode, unused code acts as a query; sortable key beside it
  always_comb begin
    push_cmd.key = {in_entry_year, in_entry_month, in_entry_day};
    unique case (in_mode)
      MODE_INSERT: push_cmd.op = OP_INSERT;
      MODE_REMOVE: push_cmd.op = OP_REMOVE;
      MODE_QUERY:  push_cmd.op = OP_QUERY;
      default:     push_cmd.op = OP_QUERY;
    endcase
  end

  // tag trimmed to the stored width
  assign tag_wide     = 32'(in_entry_tag);
  assign push_tag     = tag_wide[TAG_BITS-1:0];

endmodule

`default_nettype wire

>>> hdl/dorq_cmdq.sv
// dorq_cmdq: small command queue that decouples the front from the slot array
// depends on dorq_pkg
`default_nettype none

module dorq_cmdq #(
  parameter int WIDTH = 8
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_valid,
  output logic             push_ready,
  input  wire  [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  wire              pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import dorq_pkg::*;

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int LVL_W = $clog2(CMDQ_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             push, pop;

  assign push_ready = level_r != LVL_W'(CMDQ_DEPTH);
  assign pop_valid  = level_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointer and level update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    level_nxt  = level_r;
    if (push && !pop) begin
      level_nxt = level_r + LVL_W'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // checks
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(CMDQ_DEPTH))
    else $error("command queue level above depth");

  a_level_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> level_r == $past(level_r) + LVL_W'(1))
    else $error("command queue level did not rise on push");

  a_level_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> level_r == $past(level_r) - LVL_W'(1))
    else $error("command queue level did not fall on pop");

endmodule

`default_nettype wire

>>> hdl/dorq_back.sv
// dorq_back: shift-insert slot array that carries out queued commands and holds the result
// depends on dorq_pkg
`default_nettype none

module dorq_back #(
  parameter int QUEUE_DEPTH = dorq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = dorq_pkg::TAG_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           pop_valid,
  output logic                          pop_ready,
  input  wire dorq_pkg::dorq_cmd_t      pop_cmd,
  input  wire  [TAG_BITS-1:0]           pop_tag,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic                          out_head_valid,
  output logic [dorq_pkg::YEAR_W-1:0]   out_head_year,
  output logic [dorq_pkg::MONTH_W-1:0]  out_head_month,
  output logic [dorq_pkg::DAY_W-1:0]    out_head_day,
  output logic [dorq_pkg::TAG_W-1:0]    out_head_tag,
  output logic [dorq_pkg::FILL_W-1:0]   out_fill_count,
  output logic                          out_dropped
);
  import dorq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [KEY_W-1:0]    slot_key_r   [QUEUE_DEPTH];
  logic [KEY_W-1:0]    slot_key_nxt [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] slot_tag_r   [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] slot_tag_nxt [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] le;
  logic [CW-1:0]       count_r, count_nxt;
  logic                take, full, do_ins, do_rem, refuse;
  logic [31:0]         head_tag_wide;

  logic                out_valid_r;
  logic                head_valid_r;
  logic [YEAR_W-1:0]   head_year_r;
  logic [MONTH_W-1:0]  head_month_r;
  logic [DAY_W-1:0]    head_day_r;
  logic [TAG_W-1:0]    head_tag_r;
  logic [FILL_W-1:0]   fill_r;
  logic                dropped_r;

  // command pops whenever the result register is free or being drained
  assign pop_ready = !out_valid_r || out_ready;
  assign take      = pop_valid && pop_ready;
  assign full      = count_r == CW'(QUEUE_DEPTH);
  assign do_ins    = take && (pop_cmd.op == OP_INSERT) && !full;
  assign do_rem    = take && (pop_cmd.op == OP_REMOVE) && (count_r != '0);
  assign refuse    = take && (pop_cmd.op == OP_INSERT) && full;

  // per-slot compare and shift cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0]    down_key, up_key;
    logic [TAG_BITS-1:0] down_tag, up_tag;
    logic                at_pos;

    // slot holds a live entry not later than the new one
    assign le[i] = (CW'(i) < count_r) && (slot_key_r[i] <= pop_cmd.key);

    // neighbor sources: from below on insert, from above on remove
    if (i == 0) begin : g_first
      assign at_pos   = !le[0];
      assign down_key = pop_cmd.key;
      assign down_tag = pop_tag;
    end else begin : g_rest
      assign at_pos   = !le[i] && le[i-1];
      assign down_key = slot_key_r[i-1];
      assign down_tag = slot_tag_r[i-1];
    end

    if (i < QUEUE_DEPTH - 1) begin : g_upper
      assign up_key = slot_key_r[i+1];
      assign up_tag = slot_tag_r[i+1];
    end else begin : g_last
      assign up_key = slot_key_r[i];
      assign up_tag = slot_tag_r[i];
    end

    always_comb begin
      slot_key_nxt[i] = slot_key_r[i];
      slot_tag_nxt[i] = slot_tag_r[i];
      if (do_ins && !le[i]) begin
        slot_key_nxt[i] = at_pos ? pop_cmd.key : down_key;
        slot_tag_nxt[i] = at_pos ? pop_tag : down_tag;
      end else if (do_rem) begin
        slot_key_nxt[i] = up_key;
        slot_tag_nxt[i] = up_tag;
      end
    end

    always_ff @(posedge clk) begin
      slot_key_r[i] <= slot_key_nxt[i];
      slot_tag_r[i] <= slot_tag_nxt[i];
    end
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register loads the head after the operation
  assign head_tag_wide = 32'(slot_tag_nxt[0]);

  always_ff @(posedge clk) begin
    if (take) begin
      head_valid_r <= count_nxt != '0;
      if (count_nxt != '0) begin
        head_year_r  <= slot_key_nxt[0][KEY_W-1 -: YEAR_W];
        head_month_r <= slot_key_nxt[0][DAY_W +: MONTH_W];
        head_day_r   <= slot_key_nxt[0][DAY_W-1:0];
        head_tag_r   <= head_tag_wide[TAG_W-1:0];
      end else begin
        head_year_r  <= '0;
        head_month_r <= '0;
        head_day_r   <= '0;
        head_tag_r   <= '0;
      end
      fill_r    <= FILL_W'(count_nxt);
      dropped_r <= refuse;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_head_valid = head_valid_r;
  assign out_head_year  = head_year_r;
  assign out_head_month = head_month_r;
  assign out_head_day   = head_day_r;
  assign out_head_tag   = head_tag_r;
  assign out_fill_count = fill_r;
  assign out_dropped    = dropped_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_refused_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    refuse |=> dropped_r && (count_r == $past(count_r)))
    else $error("refused insert changed the queue or was not flagged");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_rem |=> count_r == $past(count_r) - CW'(1))
    else $error("remove did not lower the count");

  a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> head_valid_r == (count_r != '0))
    else $error("head valid disagrees with count");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CW'(2)) |-> (slot_key_r[0] <= slot_key_r[1]))
    else $error("head entry later than second entry");

endmodule

`default_nettype wire

>>> hdl/date_ordered_request_queue.sv
// date_ordered_request_queue: top level, front classifier, command queue and slot array
// depends on dorq_pkg, dorq_front, dorq_cmdq, dorq_back
//
//   channel | handshake              | payload
//   in      | in_valid / in_ready    | mode, entry date (year, month, day), entry tag
//   out     | out_valid / out_ready  | head valid, head date and tag, fill count, dropped
//
// one request transfer per cycle sustained while out_ready is high; a request goes through
// the command queue, then the result register; all slots compare and shift in parallel
// reset clears the count, the command queue and the result valid; slots are not cleared
// a stalled result register stops the array, the two-entry command queue then fills
// and in_ready drops until the result is taken
`default_nettype none

module date_ordered_request_queue #(
  parameter int QUEUE_DEPTH = dorq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = dorq_pkg::TAG_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [dorq_pkg::MODE_W-1:0]   in_mode,
  input  wire  [dorq_pkg::YEAR_W-1:0]   in_entry_year,
  input  wire  [dorq_pkg::MONTH_W-1:0]  in_entry_month,
  input  wire  [dorq_pkg::DAY_W-1:0]    in_entry_day,
  input  wire  [dorq_pkg::TAG_W-1:0]    in_entry_tag,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic                          out_head_valid,
  output logic [dorq_pkg::YEAR_W-1:0]   out_head_year,
  output logic [dorq_pkg::MONTH_W-1:0]  out_head_month,
  output logic [dorq_pkg::DAY_W-1:0]    out_head_day,
  output logic [dorq_pkg::TAG_W-1:0]    out_head_tag,
  output logic [dorq_pkg::FILL_W-1:0]   out_fill_count,
  output logic                          out_dropped
);
  import dorq_pkg::*;

  localparam int QW = $bits(dorq_cmd_t) + TAG_BITS;

  dorq_cmd_t           push_cmd, pop_cmd;
  logic [TAG_BITS-1:0] push_tag, pop_tag;
  logic                push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0]       pop_data;

  // accept and classify
  dorq_front #(
    .TAG_BITS (TAG_BITS)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_entry_year  (in_entry_year),
    .in_entry_month (in_entry_month),
    .in_entry_day   (in_entry_day),
    .in_entry_tag   (in_entry_tag),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_cmd       (push_cmd),
    .push_tag       (push_tag)
  );

  // decoupling queue
  dorq_cmdq #(
    .WIDTH (QW)
  ) u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_cmd, push_tag}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_cmd = pop_data[QW-1 -: $bits(dorq_cmd_t)];
  assign pop_tag = pop_data[TAG_BITS-1:0];

  // sorted slot array and result register
  dorq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_cmd        (pop_cmd),
    .pop_tag        (pop_tag),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_head_valid (out_head_valid),
    .out_head_year  (out_head_year),
    .out_head_month (out_head_month),
    .out_head_day   (out_head_day),
    .out_head_tag   (out_head_tag),
    .out_fill_count (out_fill_count),
    .out_dropped    (out_dropped)
  );

endmodule

`default_nettype wire

>>> sim/date_ordered_request_queue_tb.sv
// date_ordered_request_queue_tb: self-checking bench for the date-ordered request queue
// drives random and directed requests with random idling on both channels and checks
// every result against a behavioral queue model; depends on dorq_pkg and the hdl top

// one held request: date fields in compare order, then the handle
typedef struct packed {
  logic [dorq_pkg::YEAR_W-1:0]  year;
  logic [dorq_pkg::MONTH_W-1:0] month;
  logic [dorq_pkg::DAY_W-1:0]   day;
  logic [dorq_pkg::TAG_W-1:0]   tag;
} queue_slot_t;

// one result transfer
typedef struct packed {
  logic                        head_valid;
  queue_slot_t                 head;
  logic [dorq_pkg::FILL_W-1:0] fill;
  logic                        dropped;
} head_report_t;

// behavioral queue plus the reports it still owes
class queue_head_tracker;
  queue_slot_t  slots[dorq_pkg::QUEUE_DEPTH_DEF];
  int unsigned  held;
  head_report_t pending_heads[$];
  int unsigned  mismatches;

  function new();
    held       = 0;
    mismatches = 0;
  endfunction

  function dorq_pkg::dorq_key_t date_key(queue_slot_t s);
    return {s.year, s.month, s.day};
  endfunction

  // apply one accepted request and queue the report it causes
  function void note_request(logic [dorq_pkg::MODE_W-1:0] mode, queue_slot_t entry);
    head_report_t rpt;
    int unsigned  pos;
    rpt = '0;
    if (mode == dorq_pkg::MODE_INSERT) begin
      if (held >= dorq_pkg::QUEUE_DEPTH_DEF) begin
        rpt.dropped = 1'b1;
      end else begin
        // equal dates go behind the ones already held
        pos = 0;
        while (pos < held && date_key(slots[pos]) <= date_key(entry)) pos++;
        for (int unsigned i = held; i > pos; i--) slots[i] = slots[i-1];
        slots[pos] = entry;
        held++;
      end
    end else if (mode == dorq_pkg::MODE_REMOVE) begin
      if (held > 0) begin
        for (int unsigned i = 0; i + 1 < held; i++) slots[i] = slots[i+1];
        held--;
      end
    end
    if (held > 0) begin
      rpt.head_valid = 1'b1;
      rpt.head       = slots[0];
    end
    rpt.fill = held[dorq_pkg::FILL_W-1:0];
    pending_heads.push_back(rpt);
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // match a result transfer against the oldest owed report
  function void check_head(head_report_t got);
    head_report_t want;
    if (pending_heads.size() == 0) begin
      $error("result transfer with no request outstanding");
      mismatches++;
      return;
    end
    want = pending_heads.pop_front();
    compare_field("head_valid", want.head_valid, got.head_valid);
    compare_field("head_year", want.head.year, got.head.year);
    compare_field("head_month", want.head.month, got.head.month);
    compare_field("head_day", want.head.day, got.head.day);
    compare_field("head_tag", want.head.tag, got.head.tag);
    compare_field("fill_count", want.fill, got.fill);
    compare_field("dropped", want.dropped, got.dropped);
  endfunction
endclass

module date_ordered_request_queue_tb;

  localparam logic [dorq_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int unsigned RANDOM_ITEMS  = 1300;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned LONG_HOLDOFF  = 80;
  localparam int unsigned DRAIN_CYCLES  = 8;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [dorq_pkg::MODE_W-1:0]   in_mode;
  logic [dorq_pkg::YEAR_W-1:0]   in_entry_year;
  logic [dorq_pkg::MONTH_W-1:0]  in_entry_month;
  logic [dorq_pkg::DAY_W-1:0]    in_entry_day;
  logic [dorq_pkg::TAG_W-1:0]    in_entry_tag;
  logic                          out_valid;
  logic                          out_ready;
  logic                          out_head_valid;
  logic [dorq_pkg::YEAR_W-1:0]   out_head_year;
  logic [dorq_pkg::MONTH_W-1:0]  out_head_month;
  logic [dorq_pkg::DAY_W-1:0]    out_head_day;
  logic [dorq_pkg::TAG_W-1:0]    out_head_tag;
  logic [dorq_pkg::FILL_W-1:0]   out_fill_count;
  logic                          out_dropped;

  queue_head_tracker tracker;
  queue_slot_t       offered;
  head_report_t      seen;
  int unsigned       results_seen;
  int unsigned       holdoffs_done;
  int unsigned       cycle_count;

  date_ordered_request_queue u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_entry_year  (in_entry_year),
    .in_entry_month (in_entry_month),
    .in_entry_day   (in_entry_day),
    .in_entry_tag   (in_entry_tag),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_head_valid (out_head_valid),
    .out_head_year  (out_head_year),
    .out_head_month (out_head_month),
    .out_head_day   (out_head_day),
    .out_head_tag   (out_head_tag),
    .out_fill_count (out_fill_count),
    .out_dropped    (out_dropped)
  );

  // clock, period 2
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic queue_slot_t make_entry(int unsigned y, int unsigned m, int unsigned d,
                                             int unsigned t);
    queue_slot_t e;
    e.year  = y[dorq_pkg::YEAR_W-1:0];
    e.month = m[dorq_pkg::MONTH_W-1:0];
    e.day   = d[dorq_pkg::DAY_W-1:0];
    e.tag   = t[dorq_pkg::TAG_W-1:0];
    return e;
  endfunction

  // random date: clustered for ties, full calendar range, or raw field values
  function automatic queue_slot_t random_entry();
    int unsigned r;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      y = $urandom_range(2020, 2022);
      m = $urandom_range(1, 3);
      d = $urandom_range(1, 4);
    end else if (r < 88) begin
      y = $urandom_range(0, 9999);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, 31);
    end else begin
      y = $urandom;
      m = $urandom;
      d = $urandom;
    end
    return make_entry(y, m, d, $urandom);
  endfunction

  // offer one request after an optional gap and hold it until the transfer
  task automatic send_request(input logic [dorq_pkg::MODE_W-1:0] mode, input queue_slot_t entry,
                              input bit steady);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_entry_year  <= entry.year;
    in_entry_month <= entry.month;
    in_entry_day   <= entry.day;
    in_entry_tag   <= entry.tag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // transfer monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        offered = '{in_entry_year, in_entry_month, in_entry_day, in_entry_tag};
        tracker.note_request(in_mode, offered);
      end
      if (out_valid && out_ready) begin
        seen.head_valid = out_head_valid;
        seen.head       = '{out_head_year, out_head_month, out_head_day, out_head_tag};
        seen.fill       = out_fill_count;
        seen.dropped    = out_dropped;
        tracker.check_head(seen);
        results_seen++;
      end
    end
  end

  // result side: random stalls, a steady stretch and two long hold-offs
  initial begin
    int unsigned run;
    int unsigned stall;
    bit          steady;
    out_ready     <= 1'b0;
    holdoffs_done = 0;
    repeat (3) @(posedge clk);
    forever begin
      if (holdoffs_done < 2 && results_seen >= 250 + 500 * holdoffs_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLDOFF) @(posedge clk);
        holdoffs_done++;
      end else begin
        steady = (results_seen >= 600 && results_seen < 800);
        out_ready <= 1'b1;
        run = steady ? 50 : $urandom_range(1, 12);
        repeat (run) @(posedge clk);
        stall = steady ? 0 : pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // request side: reset, directed cases, random traffic, drain
  initial begin
    int unsigned                 insert_pct;
    int unsigned                 r;
    logic [dorq_pkg::MODE_W-1:0] mode;
    tracker        = new();
    results_seen   = 0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_mode        <= dorq_pkg::MODE_QUERY;
    in_entry_year  <= '0;
    in_entry_month <= '0;
    in_entry_day   <= '0;
    in_entry_tag   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue: query, remove, spare mode
    send_request(dorq_pkg::MODE_QUERY, make_entry(0, 0, 0, 0), 1'b0);
    send_request(dorq_pkg::MODE_REMOVE, make_entry(16383, 15, 31, 16'hffff), 1'b0);
    send_request(MODE_SPARE, make_entry(9999, 12, 31, 16'h1234), 1'b0);
    // field extremes, raw out-of-range dates included
    send_request(dorq_pkg::MODE_INSERT, make_entry(9999, 12, 31, 16'hffff), 1'b0);
    send_request(dorq_pkg::MODE_INSERT, make_entry(0, 1, 1, 16'h0000), 1'b0);
    send_request(dorq_pkg::MODE_INSERT, make_entry(16383, 15, 31, 16'haaaa), 1'b0);
    send_request(dorq_pkg::MODE_INSERT, make_entry(0, 0, 0, 16'h5555), 1'b0);
    // equal dates leave in arrival order
    send_request(dorq_pkg::MODE_INSERT, make_entry(2000, 6, 15, 16'h0001), 1'b0);
    send_request(dorq_pkg::MODE_INSERT, make_entry(2000, 6, 15, 16'h0002), 1'b0);
    // fill up, then inserts into a full queue are dropped
    for (int i = 0; i < 10; i++) send_request(dorq_pkg::MODE_INSERT, random_entry(), 1'b0);
    send_request(dorq_pkg::MODE_INSERT, make_entry(0, 0, 0, 16'hbeef), 1'b0);
    send_request(dorq_pkg::MODE_INSERT, make_entry(16383, 15, 31, 16'h0f0f), 1'b0);
    send_request(MODE_SPARE, random_entry(), 1'b0);
    send_request(dorq_pkg::MODE_REMOVE, random_entry(), 1'b0);
    send_request(dorq_pkg::MODE_REMOVE, random_entry(), 1'b0);

    // random traffic; insert share drifts so the queue fills and drains
    insert_pct = 50;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        r = $urandom_range(0, 3);
        insert_pct = (r == 0) ? 25 : (r == 1) ? 50 : (r == 2) ? 70 : 90;
      end
      r = $urandom_range(0, 99);
      if (r < insert_pct) mode = dorq_pkg::MODE_INSERT;
      else if (r < 92) mode = dorq_pkg::MODE_REMOVE;
      else if (r < 97) mode = dorq_pkg::MODE_QUERY;
      else mode = MODE_SPARE;
      send_request(mode, random_entry(), (n >= 400 && n < 550));
    end
    in_valid <= 1'b0;

    // wait for every owed result, then keep watching for strays for DRAIN_CYCLES
    while (tracker.pending_heads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/dorq_pkg.sv
hdl/dorq_front.sv
hdl/dorq_cmdq.sv
hdl/dorq_back.sv
hdl/date_ordered_request_queue.sv
sim/date_ordered_request_queue_tb.sv
